>>> src/se2pc_pkg.sv
// ----------------------------------------------------------------------------
// se2pc_pkg
// Shared widths, payload types, opcodes and the CORDIC arc table for the
// planar pose compose / relative pipeline.
// ----------------------------------------------------------------------------
package se2pc_pkg;

   // Field widths
   localparam int COORD_WIDTH     = 32;
   localparam int ANGLE_WIDTH     = 16;
   localparam int ROTATION_STAGES = 16;

   // Internal arithmetic
   localparam int GUARD_BITS    = 8;
   localparam int TURN_WIDTH    = 32;
   localparam int ARC_TABLE_LEN = 24;
   localparam int ARC_IDX_W     = $clog2(ARC_TABLE_LEN);
   // Position difference is one bit wider than a coordinate
   localparam int VEC_WIDTH     = COORD_WIDTH + 1;
   // Guard bits, fold negate and CORDIC growth (about 2.33x) fit in this
   localparam int WORK_WIDTH    = COORD_WIDTH + GUARD_BITS + 4;
   localparam logic [31:0] GAIN_INV = 32'd2608131496;

   // Operation codes
   localparam logic OP_COMPOSE  = 1'b0;
   localparam logic OP_RELATIVE = 1'b1;

   typedef struct packed {
      logic                          op;
      logic signed [COORD_WIDTH-1:0] base_x;
      logic signed [COORD_WIDTH-1:0] base_y;
      logic signed [ANGLE_WIDTH-1:0] base_heading;
      logic signed [COORD_WIDTH-1:0] delta_x;
      logic signed [COORD_WIDTH-1:0] delta_y;
      logic signed [ANGLE_WIDTH-1:0] delta_heading;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] out_x;
      logic signed [COORD_WIDTH-1:0] out_y;
      logic signed [ANGLE_WIDTH-1:0] out_heading;
      logic                          overflow;
   } rsp_type;

   // Values that ride along beside the rotation
   typedef struct packed {
      logic [ANGLE_WIDTH-1:0]        heading;
      logic signed [COORD_WIDTH-1:0] off_x;
      logic signed [COORD_WIDTH-1:0] off_y;
   } side_type;

   // Rotation pipeline payload
   typedef struct packed {
      logic signed [WORK_WIDTH-1:0] x;
      logic signed [WORK_WIDTH-1:0] y;
      logic [TURN_WIDTH-1:0]        turn;
      side_type                     side;
   } rot_type;

   // atan(2^-i) as a fraction of a full turn, 32-bit
   function automatic logic [TURN_WIDTH-1:0] arc_angle(input logic [ARC_IDX_W-1:0] idx);
      logic [TURN_WIDTH-1:0] a;
      unique case (idx)
         5'd0:    a = 32'h20000000;
         5'd1:    a = 32'h12E4051E;
         5'd2:    a = 32'h09FB385B;
         5'd3:    a = 32'h051111D4;
         5'd4:    a = 32'h028B0D43;
         5'd5:    a = 32'h0145D7E1;
         5'd6:    a = 32'h00A2F61E;
         5'd7:    a = 32'h00517C55;
         5'd8:    a = 32'h0028BE53;
         5'd9:    a = 32'h00145F2F;
         5'd10:   a = 32'h000A2F98;
         5'd11:   a = 32'h000517CC;
         5'd12:   a = 32'h00028BE6;
         5'd13:   a = 32'h000145F3;
         5'd14:   a = 32'h0000A2FA;
         5'd15:   a = 32'h0000517D;
         5'd16:   a = 32'h000028BE;
         5'd17:   a = 32'h0000145F;
         5'd18:   a = 32'h00000A30;
         5'd19:   a = 32'h00000518;
         5'd20:   a = 32'h0000028C;
         5'd21:   a = 32'h00000146;
         5'd22:   a = 32'h000000A3;
         5'd23:   a = 32'h00000051;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

>>> src/se2_pose_compose_relative.sv
// ----------------------------------------------------------------------------
// se2_pose_compose_relative
// Planar pose composition and relative pose, CORDIC rotation, saturating.
// ----------------------------------------------------------------------------
// Fully pipelined: one pose pair per cycle unless rsp_stall is high and
// every stage holds an item, which then stalls the input side. Each
// CORDIC iteration is its own register stage; around it sit an operand
// stage, a quadrant fold, the gain-correction multiply (two partial products
// per axis), its recombination, rounding, and the offset add with saturation
// feeding the output register. Every stage carries a valid bit, and stalls
// only back up until the first empty stage, so input transfers continue
// while a result waits on rsp_stall as long as the pipeline has a bubble.
module se2_pose_compose_relative #(
   parameter int ROTATION_STAGES = se2pc_pkg::ROTATION_STAGES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  se2pc_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output se2pc_pkg::rsp_type  rsp_data
);

   localparam int CW   = se2pc_pkg::COORD_WIDTH;
   localparam int AW   = se2pc_pkg::ANGLE_WIDTH;
   localparam int VW   = se2pc_pkg::VEC_WIDTH;
   localparam int WW   = se2pc_pkg::WORK_WIDTH;
   localparam int TW   = se2pc_pkg::TURN_WIDTH;
   localparam int GB   = se2pc_pkg::GUARD_BITS;
   localparam int LO_W = WW / 2;
   localparam int HI_W = WW - LO_W;
   localparam int PW   = WW + 33;
   localparam int RW   = WW + 1 - GB;
   localparam int SW   = RW + 1;

   localparam int NUM_ITER = (ROTATION_STAGES < se2pc_pkg::ARC_TABLE_LEN) ?
                             ROTATION_STAGES : se2pc_pkg::ARC_TABLE_LEN;

   // Stage positions in the valid vector
   localparam int PREP_IDX = 0;
   localparam int FOLD_IDX = 1;
   localparam int COR_IDX  = 2;
   localparam int MUL_IDX  = NUM_ITER + 2;
   localparam int CMB_IDX  = NUM_ITER + 3;
   localparam int RND_IDX  = NUM_ITER + 4;
   localparam int OUT_IDX  = NUM_ITER + 5;
   localparam int NV       = NUM_ITER + 6;

   localparam logic signed [WW:0]   HALF   = (WW+1)'(1) <<< (GB - 1);
   localparam logic signed [CW-1:0] MAX_CW = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] MIN_CW = {1'b1, {(CW-1){1'b0}}};

   logic [NV-1:0] stage_vld;
   logic [NV-1:0] stage_en;

   // ------------------------------------------------------------------
   // Stage enables: a stage loads when some stage at or after it is
   // empty, or the output is being taken
   // ------------------------------------------------------------------
   for (genvar k = 0; k < NV; k++) begin : g_en
      assign stage_en[k] = ~rsp_stall | ~(&stage_vld[NV-1:k]);
   end

   assign req_stall = ~stage_en[PREP_IDX];

   // ------------------------------------------------------------------
   // Operand stage: pick vector, turn, offset and heading
   // ------------------------------------------------------------------
   logic                 prep_vld_ff;
   logic signed [VW-1:0] prep_x_ff,    prep_x_in;
   logic signed [VW-1:0] prep_y_ff,    prep_y_in;
   logic [TW-1:0]        prep_turn_ff, prep_turn_in;
   se2pc_pkg::side_type  prep_side_ff, prep_side_in;
   logic [TW-1:0]        base_turn;
   logic [TW-1:0]        delta_turn;

   assign base_turn  = {req_data.base_heading,  {(TW-AW){1'b0}}};
   assign delta_turn = {req_data.delta_heading, {(TW-AW){1'b0}}};

   always_comb begin
      prep_x_in    = VW'(req_data.delta_x);
      prep_y_in    = VW'(req_data.delta_y);
      prep_turn_in = base_turn;
      prep_side_in.heading = AW'(req_data.base_heading + req_data.delta_heading);
      prep_side_in.off_x   = req_data.base_x;
      prep_side_in.off_y   = req_data.base_y;
      if (req_data.op == se2pc_pkg::OP_RELATIVE) begin
         prep_x_in    = VW'(req_data.base_x) - VW'(req_data.delta_x);
         prep_y_in    = VW'(req_data.base_y) - VW'(req_data.delta_y);
         prep_turn_in = TW'(0) - delta_turn;
         prep_side_in.heading = AW'(req_data.base_heading - req_data.delta_heading);
         prep_side_in.off_x   = '0;
         prep_side_in.off_y   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_vld_ff <= 1'b0;
      end else if (stage_en[PREP_IDX]) begin
         prep_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[PREP_IDX] && req_valid) begin
         prep_x_ff    <= prep_x_in;
         prep_y_ff    <= prep_y_in;
         prep_turn_ff <= prep_turn_in;
         prep_side_ff <= prep_side_in;
      end
   end

   // ------------------------------------------------------------------
   // Fold stage: add guard bits, move the turn into [-1/4, 1/4)
   // ------------------------------------------------------------------
   logic                 fold_vld_ff;
   se2pc_pkg::rot_type   fold_ff, fold_in;
   logic signed [WW-1:0] guard_x;
   logic signed [WW-1:0] guard_y;
   logic                 flip;

   assign guard_x = WW'(prep_x_ff) <<< GB;
   assign guard_y = WW'(prep_y_ff) <<< GB;
   assign flip    = prep_turn_ff[TW-1] ^ prep_turn_ff[TW-2];

   always_comb begin
      fold_in.x    = guard_x;
      fold_in.y    = guard_y;
      fold_in.turn = prep_turn_ff;
      fold_in.side = prep_side_ff;
      if (flip) begin
         fold_in.x    = -guard_x;
         fold_in.y    = -guard_y;
         fold_in.turn = {~prep_turn_ff[TW-1], prep_turn_ff[TW-2:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_vld_ff <= 1'b0;
      end else if (stage_en[FOLD_IDX]) begin
         fold_vld_ff <= prep_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[FOLD_IDX] && prep_vld_ff) begin
         fold_ff <= fold_in;
      end
   end

   assign stage_vld[PREP_IDX] = prep_vld_ff;
   assign stage_vld[FOLD_IDX] = fold_vld_ff;

   // ------------------------------------------------------------------
   // CORDIC iterations, one register stage each
   // ------------------------------------------------------------------
   logic [NUM_ITER:0]  cor_vld;
   se2pc_pkg::rot_type cor_rot [NUM_ITER+1];

   assign cor_vld[0] = fold_vld_ff;
   assign cor_rot[0] = fold_ff;

   for (genvar i = 0; i < NUM_ITER; i++) begin : g_cordic
      se2pc_cordic_stage #(
         .STAGE (i)
      ) u_stage (
         .clock (clock),
         .reset (reset),
         .en_i  (stage_en[COR_IDX+i]),
         .vld_i (cor_vld[i]),
         .rot_i (cor_rot[i]),
         .vld_o (cor_vld[i+1]),
         .rot_o (cor_rot[i+1])
      );
      assign stage_vld[COR_IDX+i] = cor_vld[i+1];
   end

   // ------------------------------------------------------------------
   // Gain correction, partial products: v * GAIN_INV split at LO_W
   // ------------------------------------------------------------------
   se2pc_pkg::rot_type       cor_last;
   logic                     mul_vld_ff;
   logic [LO_W+31:0]         mul_lo_x_ff, mul_lo_x_in;
   logic [LO_W+31:0]         mul_lo_y_ff, mul_lo_y_in;
   logic signed [HI_W+32:0]  mul_hi_x_ff, mul_hi_x_in;
   logic signed [HI_W+32:0]  mul_hi_y_ff, mul_hi_y_in;
   se2pc_pkg::side_type      mul_side_ff;
   logic signed [HI_W+32:0]  gain_s;

   assign cor_last = cor_rot[NUM_ITER];
   assign gain_s   = $signed((HI_W+33)'({1'b0, se2pc_pkg::GAIN_INV}));

   assign mul_lo_x_in = (LO_W+32)'(cor_last.x[LO_W-1:0]) * (LO_W+32)'(se2pc_pkg::GAIN_INV);
   assign mul_lo_y_in = (LO_W+32)'(cor_last.y[LO_W-1:0]) * (LO_W+32)'(se2pc_pkg::GAIN_INV);
   assign mul_hi_x_in = (HI_W+33)'($signed(cor_last.x[WW-1:LO_W])) * gain_s;
   assign mul_hi_y_in = (HI_W+33)'($signed(cor_last.y[WW-1:LO_W])) * gain_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
      end else if (stage_en[MUL_IDX]) begin
         mul_vld_ff <= cor_vld[NUM_ITER];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[MUL_IDX] && cor_vld[NUM_ITER]) begin
         mul_lo_x_ff <= mul_lo_x_in;
         mul_lo_y_ff <= mul_lo_y_in;
         mul_hi_x_ff <= mul_hi_x_in;
         mul_hi_y_ff <= mul_hi_y_in;
         mul_side_ff <= cor_last.side;
      end
   end

   assign stage_vld[MUL_IDX] = mul_vld_ff;

   // ------------------------------------------------------------------
   // Recombine partial products and drop 32 fraction bits (floor)
   // ------------------------------------------------------------------
   logic                 cmb_vld_ff;
   logic signed [PW-1:0] prod_x;
   logic signed [PW-1:0] prod_y;
   logic signed [WW-1:0] cmb_x_ff;
   logic signed [WW-1:0] cmb_y_ff;
   se2pc_pkg::side_type  cmb_side_ff;

   assign prod_x = (PW'(mul_hi_x_ff) <<< LO_W) + PW'(mul_lo_x_ff);
   assign prod_y = (PW'(mul_hi_y_ff) <<< LO_W) + PW'(mul_lo_y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cmb_vld_ff <= 1'b0;
      end else if (stage_en[CMB_IDX]) begin
         cmb_vld_ff <= mul_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[CMB_IDX] && mul_vld_ff) begin
         cmb_x_ff    <= prod_x[WW+31:32];
         cmb_y_ff    <= prod_y[WW+31:32];
         cmb_side_ff <= mul_side_ff;
      end
   end

   assign stage_vld[CMB_IDX] = cmb_vld_ff;

   // ------------------------------------------------------------------
   // Round away the guard bits (add half, floor shift)
   // ------------------------------------------------------------------
   logic                 rnd_vld_ff;
   logic signed [WW:0]   rnd_sum_x;
   logic signed [WW:0]   rnd_sum_y;
   logic signed [RW-1:0] rnd_x_ff;
   logic signed [RW-1:0] rnd_y_ff;
   se2pc_pkg::side_type  rnd_side_ff;

   assign rnd_sum_x = (WW+1)'(cmb_x_ff) + HALF;
   assign rnd_sum_y = (WW+1)'(cmb_y_ff) + HALF;

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_vld_ff <= 1'b0;
      end else if (stage_en[RND_IDX]) begin
         rnd_vld_ff <= cmb_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[RND_IDX] && cmb_vld_ff) begin
         rnd_x_ff    <= rnd_sum_x[WW:GB];
         rnd_y_ff    <= rnd_sum_y[WW:GB];
         rnd_side_ff <= cmb_side_ff;
      end
   end

   assign stage_vld[RND_IDX] = rnd_vld_ff;

   // ------------------------------------------------------------------
   // Add base offset, saturate, hold in the output register
   // ------------------------------------------------------------------
   logic                 rsp_valid_ff;
   se2pc_pkg::rsp_type   rsp_ff, rsp_in;
   logic signed [SW-1:0] fin_x;
   logic signed [SW-1:0] fin_y;
   logic                 ovf_x;
   logic                 ovf_y;

   assign fin_x = SW'(rnd_x_ff) + SW'(rnd_side_ff.off_x);
   assign fin_y = SW'(rnd_y_ff) + SW'(rnd_side_ff.off_y);
   assign ovf_x = ~(&fin_x[SW-1:CW-1]) & (|fin_x[SW-1:CW-1]);
   assign ovf_y = ~(&fin_y[SW-1:CW-1]) & (|fin_y[SW-1:CW-1]);

   always_comb begin
      rsp_in.out_x       = fin_x[CW-1:0];
      rsp_in.out_y       = fin_y[CW-1:0];
      rsp_in.out_heading = rnd_side_ff.heading;
      rsp_in.overflow    = ovf_x | ovf_y;
      if (ovf_x) begin
         rsp_in.out_x = fin_x[SW-1] ? MIN_CW : MAX_CW;
      end
      if (ovf_y) begin
         rsp_in.out_y = fin_y[SW-1] ? MIN_CW : MAX_CW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage_en[OUT_IDX]) begin
         rsp_valid_ff <= rnd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[OUT_IDX] && rnd_vld_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign stage_vld[OUT_IDX] = rsp_valid_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> (stage_vld == '0))
      else $error("pipeline valid bits not cleared by reset");

   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      fold_vld_ff |-> (fold_ff.turn[TW-1] == fold_ff.turn[TW-2]))
      else $error("folded turn outside the quarter-circle window");

   a_round_hold: assert property (@(posedge clock) disable iff (reset)
      (rnd_vld_ff && !stage_en[RND_IDX]) |=>
         (rnd_vld_ff && $stable(rnd_x_ff) && $stable(rnd_y_ff)))
      else $error("blocked round stage lost or changed its item");

   a_ovf_clipped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.overflow) |->
         (rsp_ff.out_x == MAX_CW || rsp_ff.out_x == MIN_CW ||
          rsp_ff.out_y == MAX_CW || rsp_ff.out_y == MIN_CW))
      else $error("overflow flagged without a clipped coordinate");

endmodule

>>> src/se2pc_cordic_stage.sv
// ----------------------------------------------------------------------------
// se2pc_cordic_stage
// One registered CORDIC micro-rotation in rotation mode, with its valid bit.
// ----------------------------------------------------------------------------
module se2pc_cordic_stage #(
   parameter int STAGE = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en_i,
   input  logic                 vld_i,
   input  se2pc_pkg::rot_type   rot_i,
   output logic                 vld_o,
   output se2pc_pkg::rot_type   rot_o
);

   localparam int IW = se2pc_pkg::ARC_IDX_W;
   localparam int TW = se2pc_pkg::TURN_WIDTH;
   localparam logic [IW-1:0] SIDX = IW'(STAGE);
   localparam logic [TW-1:0] ARC  = se2pc_pkg::arc_angle(SIDX);

   logic                          vld_ff;
   se2pc_pkg::rot_type            rot_ff;
   se2pc_pkg::rot_type            rot_in;
   logic signed [se2pc_pkg::WORK_WIDTH-1:0] sx;
   logic signed [se2pc_pkg::WORK_WIDTH-1:0] sy;

   // Shifted cross terms (floor shifts)
   assign sy = rot_i.y >>> STAGE;
   assign sx = rot_i.x >>> STAGE;

   // Rotate toward zero residual turn
   always_comb begin
      rot_in = rot_i;
      if (!rot_i.turn[TW-1]) begin
         rot_in.x    = rot_i.x - sy;
         rot_in.y    = rot_i.y + sx;
         rot_in.turn = rot_i.turn - ARC;
      end else begin
         rot_in.x    = rot_i.x + sy;
         rot_in.y    = rot_i.y - sx;
         rot_in.turn = rot_i.turn + ARC;
      end
   end

   // Advance when the stage ahead has room
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en_i) begin
         vld_ff <= vld_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en_i && vld_i) begin
         rot_ff <= rot_in;
      end
   end

   assign vld_o = vld_ff;
   assign rot_o = rot_ff;

endmodule

>>> sim/se2pc_pose_checker.sv
// ----------------------------------------------------------------------------
// se2pc_pose_checker
// Watches both channels of the pose compose / relative block, predicts each
// result pose with a bit-exact CORDIC model and compares field by field.
// ----------------------------------------------------------------------------
module se2pc_pose_checker
   import se2pc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // Fixed-point details of the rotation
   localparam int          GUARD_SHIFT = 8;
   localparam int          ARC_COUNT   = 24;
   localparam longint      INV_GAIN    = 64'sd2608131496;
   localparam longint      COORD_HI    = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
   localparam longint      COORD_LO    = -COORD_HI - 1;

   // atan(2^-i) in units of a full turn over 2^32
   localparam logic [31:0] ARC_TURNS [ARC_COUNT] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   rsp_type expected_poses [$];

   // Multiply by the inverse CORDIC gain over 2^32, rounding toward minus infinity
   function automatic longint apply_inv_gain(input longint v);
      longint          hi;
      longint unsigned lo_prod;
      hi      = v >>> 32;
      lo_prod = {32'd0, v[31:0]} * 64'd2608131496;
      return hi * INV_GAIN + longint'(lo_prod >> 32);
   endfunction

   // Rotate (vx, vy) by a 32-bit turn count
   task automatic rotate_by_turn(inout longint vx, inout longint vy, input logic [31:0] turn);
      longint      x, y, step_x, step_y;
      logic [31:0] t, fold_test;
      x = vx * (64'sd1 <<< GUARD_SHIFT);
      y = vy * (64'sd1 <<< GUARD_SHIFT);
      t = turn;
      // fold turns in the left half plane by a half-turn negation
      fold_test = t + 32'h4000_0000;
      if (fold_test[31]) begin
         x = -x;
         y = -y;
         t = t - 32'h8000_0000;
      end
      for (int i = 0; i < ROTATION_STAGES && i < ARC_COUNT; i++) begin
         step_x = y >>> i;
         step_y = x >>> i;
         if (!t[31]) begin
            x = x - step_x;
            y = y + step_y;
            t = t - ARC_TURNS[i];
         end else begin
            x = x + step_x;
            y = y - step_y;
            t = t + ARC_TURNS[i];
         end
      end
      x  = apply_inv_gain(x);
      y  = apply_inv_gain(y);
      vx = (x + (64'sd1 <<< (GUARD_SHIFT - 1))) >>> GUARD_SHIFT;
      vy = (y + (64'sd1 <<< (GUARD_SHIFT - 1))) >>> GUARD_SHIFT;
   endtask

   // Clip to the coordinate range, flag any clipping
   function automatic logic [COORD_WIDTH-1:0] clip_coord(input longint v, inout logic clipped);
      if (v > COORD_HI) begin
         clipped = 1'b1;
         return COORD_HI[COORD_WIDTH-1:0];
      end
      if (v < COORD_LO) begin
         clipped = 1'b1;
         return COORD_LO[COORD_WIDTH-1:0];
      end
      return v[COORD_WIDTH-1:0];
   endfunction

   // Work out the pose that one transfer should produce
   task automatic predict_pose(input req_type r, output rsp_type pose);
      longint                 px, py;
      logic [31:0]            turn;
      logic [ANGLE_WIDTH-1:0] hdg;
      logic                   clipped;
      clipped = 1'b0;
      if (r.op == OP_COMPOSE) begin
         turn = {r.base_heading, {(32 - ANGLE_WIDTH){1'b0}}};
         px   = longint'($signed(r.delta_x));
         py   = longint'($signed(r.delta_y));
         rotate_by_turn(px, py, turn);
         px   = px + longint'($signed(r.base_x));
         py   = py + longint'($signed(r.base_y));
         hdg  = r.base_heading + r.delta_heading;
      end else begin
         turn = 32'd0 - {r.delta_heading, {(32 - ANGLE_WIDTH){1'b0}}};
         px   = longint'($signed(r.base_x)) - longint'($signed(r.delta_x));
         py   = longint'($signed(r.base_y)) - longint'($signed(r.delta_y));
         rotate_by_turn(px, py, turn);
         hdg  = r.base_heading - r.delta_heading;
      end
      pose.out_x       = clip_coord(px, clipped);
      pose.out_y       = clip_coord(py, clipped);
      pose.out_heading = hdg;
      pose.overflow    = clipped;
   endtask

   // Print one line per mismatch and count it
   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t ns: %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   // Pop and compare on each result transfer, push a prediction on each request transfer
   always @(posedge clock) begin : watch_channels
      rsp_type want;
      rsp_type pose;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_poses.size() == 0) begin
               report_mismatch("result with no request outstanding", 1, 0);
            end else begin
               want = expected_poses.pop_front();
               if (rsp_data.out_x !== want.out_x)
                  report_mismatch("out_x", $signed(rsp_data.out_x), $signed(want.out_x));
               if (rsp_data.out_y !== want.out_y)
                  report_mismatch("out_y", $signed(rsp_data.out_y), $signed(want.out_y));
               if (rsp_data.out_heading !== want.out_heading)
                  report_mismatch("out_heading", $signed(rsp_data.out_heading),
                                  $signed(want.out_heading));
               if (rsp_data.overflow !== want.overflow)
                  report_mismatch("overflow", rsp_data.overflow, want.overflow);
            end
         end
         if (req_valid && !req_stall) begin
            predict_pose(req_data, pose);
            expected_poses.push_back(pose);
         end
      end
      pending = expected_poses.size();
   end

endmodule

>>> sim/tb_se2_pose_compose_relative.sv
// ----------------------------------------------------------------------------
// tb_se2_pose_compose_relative
// Drives directed and random pose pairs into the compose / relative block
// under three sender and receiver idle mixes, and gives the final verdict
// from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_se2_pose_compose_relative;
   timeunit 1ns;
   timeprecision 1ps;
   import se2pc_pkg::*;

   localparam logic signed [31:0] C_MAX       = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] C_MIN       = 32'sh8000_0000;
   localparam logic signed [31:0] ONE_METER   = 32'sh0001_0000;
   localparam logic signed [15:0] H_MAX       = 16'sh7FFF;
   localparam logic signed [15:0] H_MIN       = 16'sh8000;
   localparam logic signed [15:0] H_QUARTER   = 16'sh4000;
   localparam logic signed [15:0] H_ZERO      = 16'sd0;
   localparam logic signed [15:0] H_ONE       = 16'sd1;
   localparam int                 PHASE_ITEMS = 235;
   localparam int                 SETTLE      = 40;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int      fail_count;
   int      pending;
   int      send_idle_pct  = 18;
   int      stall_pct      = 66;

   always #6 clock = ~clock;

   se2_pose_compose_relative dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   se2pc_pose_checker pose_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Receiver back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // Hard stop well past the slowest correct run
   initial begin
      #3_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic req_type pose_pair(input logic op,
                                         input logic signed [31:0] bx, by,
                                         input logic signed [15:0] bh,
                                         input logic signed [31:0] dx, dy,
                                         input logic signed [15:0] dh);
      req_type r;
      r.op            = op;
      r.base_x        = bx;
      r.base_y        = by;
      r.base_heading  = bh;
      r.delta_x       = dx;
      r.delta_y       = dy;
      r.delta_heading = dh;
      return r;
   endfunction

   // Mix full-range, small and near-limit coordinates
   function automatic logic signed [31:0] random_coord();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(5))
         0, 1: return r;
         2:    return {{12{r[19]}}, r[19:0]};
         3:    return C_MAX - $urandom_range(255);
         4:    return C_MIN + $urandom_range(255);
         default: return {{16{r[15]}}, r[15:0]};
      endcase
   endfunction

   // Mostly random headings, sometimes fold and wrap boundaries
   function automatic logic signed [15:0] random_heading();
      logic signed [15:0] corners [7];
      corners = '{16'sd0, H_QUARTER, -H_QUARTER, H_MIN, H_MAX, 16'sd1, -16'sd1};
      if ($urandom_range(3) == 0)
         return corners[$urandom_range(6)];
      return 16'($urandom);
   endfunction

   function automatic req_type random_pose_pair();
      return pose_pair($urandom_range(1) ? OP_RELATIVE : OP_COMPOSE,
                       random_coord(), random_coord(), random_heading(),
                       random_coord(), random_coord(), random_heading());
   endfunction

   // Present one pose pair, idling first at random, and hold it until the transfer
   task automatic send_pose(input req_type item);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Drop valid and hold off until every predicted result has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
   endtask

   task automatic send_random(input int count);
      for (int n = 0; n < count; n++)
         send_pose(random_pose_pair());
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Phase 1: light sender idling, heavy receiver stalls
      send_idle_pct = 18;
      stall_pct     = 66;

      // compose: zero, positive saturation, heading wrap to pi
      send_pose(pose_pair(OP_COMPOSE, 0, 0, H_ZERO, 0, 0, H_ZERO));
      send_pose(pose_pair(OP_COMPOSE, C_MAX, C_MAX, H_ZERO, C_MAX, C_MAX, H_ZERO));
      send_pose(pose_pair(OP_COMPOSE, C_MIN, C_MIN, H_MIN, C_MIN, C_MIN, H_MIN));
      send_pose(pose_pair(OP_COMPOSE, ONE_METER, -ONE_METER, H_MAX, 3 * ONE_METER, 5,
                          H_ONE));
      // compose: quadrant fold boundaries
      send_pose(pose_pair(OP_COMPOSE, 0, 0, H_QUARTER, ONE_METER, 0, 16'sd100));
      send_pose(pose_pair(OP_COMPOSE, 0, 0, -H_QUARTER, 0, ONE_METER, -16'sd100));
      send_pose(pose_pair(OP_COMPOSE, 0, 0, H_QUARTER - H_ONE, ONE_METER, ONE_METER,
                          H_ZERO));
      send_pose(pose_pair(OP_COMPOSE, 0, 0, H_MIN, C_MAX, C_MIN, H_MAX));
      send_pose(pose_pair(OP_COMPOSE, 12345, -999, 16'sh2000, C_MAX, C_MAX - 7, 16'sh2000));
      send_pose(pose_pair(OP_COMPOSE, -1, -1, -H_ONE, -1, -1, -H_ONE));
      send_pose(pose_pair(OP_COMPOSE, C_MAX, C_MIN, -H_ONE, C_MIN, C_MIN, H_MIN));
      // relative: wide difference, both signs
      send_pose(pose_pair(OP_RELATIVE, C_MAX, C_MAX, H_ZERO, C_MIN, C_MIN, H_ZERO));
      send_pose(pose_pair(OP_RELATIVE, C_MIN, C_MIN, H_ZERO, C_MAX, C_MAX, H_ZERO));
      send_pose(pose_pair(OP_RELATIVE, C_MAX, 0, 16'sd77, C_MIN, 0, H_QUARTER));
      // relative: heading wrap and half-turn delta
      send_pose(pose_pair(OP_RELATIVE, 5, 6, -H_QUARTER, 7, 8, H_QUARTER));
      send_pose(pose_pair(OP_RELATIVE, 3 * ONE_METER / 2, -2 * ONE_METER, H_ZERO, 0, 0,
                          H_MIN));
      send_pose(pose_pair(OP_RELATIVE, ONE_METER, ONE_METER, H_MIN, -ONE_METER, 0, H_MAX));
      send_pose(pose_pair(OP_RELATIVE, 4242, -4242, 16'sd900, 4242, -4242, 16'sd12345));
      send_pose(pose_pair(OP_RELATIVE, -1, 1, -H_ONE, 1, -1, H_ONE));
      send_pose(pose_pair(OP_RELATIVE, C_MIN, C_MAX, H_MAX, C_MAX, C_MIN, H_MIN));

      send_random(PHASE_ITEMS / 2);
      wait_drained();
      send_random(PHASE_ITEMS - PHASE_ITEMS / 2);
      wait_drained();

      // Phase 2: heavy sender idling, light receiver stalls
      send_idle_pct = 66;
      stall_pct     = 18;
      send_random(PHASE_ITEMS);
      wait_drained();

      // Phase 3: full rate both ways
      send_idle_pct = 0;
      stall_pct     = 0;
      send_random(PHASE_ITEMS);
      wait_drained();

      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
